// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the decoder RTL. Each macro samples on the
// rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold at the same edge.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/nfd_pkg.sv =====
// ----------------------------------------------------------------------------
// nfd_pkg
// Types and constants shared by the infrared frame decoder modules.
// ----------------------------------------------------------------------------
package nfd_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned BIT_IDX_W   = 5;
  localparam int unsigned CFG_IDX_W   = 3;

  // Pairs in a well-formed frame: one start pair and 32 data pairs.
  localparam logic [CNT_W-1:0] FRAME_PAIRS = CNT_W'(33);
  localparam logic [CNT_W-1:0] LAST_IDX    = CNT_W'(32);
  localparam logic [CNT_W-1:0] COUNTER_MAX = CNT_W'(63);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_START_HIGH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = CFG_IDX_W'(6);

  localparam int unsigned TOL_RESET = 4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_BAD_BIT   = 2'd2,
    ST_BAD_LEN   = 2'd3
  } status_t;

  // Template match results for the pair held in the input register.
  typedef struct packed {
    logic start_ok;
    logic zero_ok;
    logic one_ok;
  } match_flags_t;

  // Frame state made visible for checking.
  typedef struct packed {
    logic [CNT_W-1:0]  pair_cnt;
    status_t           err_code;
    logic [DATA_W-1:0] shift_word;
  } frame_state_t;

endpackage

// ===== rtl/core/nfd_if.sv =====
// ----------------------------------------------------------------------------
// nfd_if
// Valid/ready channel interfaces for pulse pairs, frame results and
// configuration writes.
// ----------------------------------------------------------------------------
interface nfd_in_if #(
  parameter int unsigned W = 16
);
  logic         valid;
  logic         ready;
  logic [W-1:0] low_time;
  logic [W-1:0] high_time;
  logic         frame_end;

  modport source (output valid, low_time, high_time, frame_end, input ready);
  modport sink   (input valid, low_time, high_time, frame_end, output ready);
endinterface

interface nfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] data_word;

  modport source (output valid, status, data_word, input ready);
  modport sink   (input valid, status, data_word, output ready);
endinterface

interface nfd_cfg_if #(
  parameter int unsigned W = 16
);
  logic         valid;
  logic         ready;
  logic [2:0]   index;
  logic [W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/nfd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// nfd_cfg_regs
// Template and tolerance registers, written one word at a time.
// ----------------------------------------------------------------------------
module nfd_cfg_regs #(
  parameter int unsigned W = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [nfd_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [W-1:0]                wr_data,
  output logic [W-1:0]                start_low,
  output logic [W-1:0]                start_high,
  output logic [W-1:0]                zero_low,
  output logic [W-1:0]                zero_high,
  output logic [W-1:0]                one_low,
  output logic [W-1:0]                one_high,
  output logic [W-1:0]                tolerance
);
  import nfd_pkg::*;

  logic [W-1:0] start_low_r, start_high_r, zero_low_r, zero_high_r;
  logic [W-1:0] one_low_r, one_high_r, tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_low_r  <= '0;
      start_high_r <= '0;
      zero_low_r   <= '0;
      zero_high_r  <= '0;
      one_low_r    <= '0;
      one_high_r   <= '0;
      tol_r        <= W'(TOL_RESET);
    end else if (wr_en) begin
      case (wr_index)
        CFG_START_LOW:  start_low_r  <= wr_data;
        CFG_START_HIGH: start_high_r <= wr_data;
        CFG_ZERO_LOW:   zero_low_r   <= wr_data;
        CFG_ZERO_HIGH:  zero_high_r  <= wr_data;
        CFG_ONE_LOW:    one_low_r    <= wr_data;
        CFG_ONE_HIGH:   one_high_r   <= wr_data;
        CFG_TOLERANCE:  tol_r        <= wr_data;
        default: ;
      endcase
    end
  end

  assign start_low  = start_low_r;
  assign start_high = start_high_r;
  assign zero_low   = zero_low_r;
  assign zero_high  = zero_high_r;
  assign one_low    = one_low_r;
  assign one_high   = one_high_r;
  assign tolerance  = tol_r;

endmodule

// ===== rtl/core/nfd_match.sv =====
// ----------------------------------------------------------------------------
// nfd_match
// Compares a measured pulse pair with one template: both absolute
// differences must be strictly below the tolerance.
// ----------------------------------------------------------------------------
module nfd_match #(
  parameter int unsigned W = 16
) (
  input  logic [W-1:0] low_time,
  input  logic [W-1:0] high_time,
  input  logic [W-1:0] exp_low,
  input  logic [W-1:0] exp_high,
  input  logic [W-1:0] tolerance,
  output logic         hit
);
  logic [W-1:0] diff_low, diff_high;

  assign diff_low  = (low_time >= exp_low)   ? (low_time - exp_low)   : (exp_low - low_time);
  assign diff_high = (high_time >= exp_high) ? (high_time - exp_high) : (exp_high - high_time);
  assign hit       = (diff_low < tolerance) && (diff_high < tolerance);

endmodule

// ===== rtl/core/nfd_frame_ctrl.sv =====
// ----------------------------------------------------------------------------
// nfd_frame_ctrl
// Input register, frame state (pair counter, assembled word, first error)
// and result register.
// ----------------------------------------------------------------------------
module nfd_frame_ctrl #(
  parameter int unsigned W = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // pulse pair input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [W-1:0]                in_low_time,
  input  logic [W-1:0]                in_high_time,
  input  logic                        in_frame_end,
  // held pair towards the comparators, and their verdicts
  output logic [W-1:0]                pair_low,
  output logic [W-1:0]                pair_high,
  input  nfd_pkg::match_flags_t       flags,
  // result output
  output logic                        out_valid,
  input  logic                        out_ready,
  output nfd_pkg::status_t            out_status,
  output logic [nfd_pkg::DATA_W-1:0]  out_data_word,
  output nfd_pkg::frame_state_t       state_view
);
  import nfd_pkg::*;

  logic              in_v_r;
  logic [W-1:0]      low_r, high_r;
  logic              fe_r;
  logic              advance;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] shift_r, shift_nxt;
  status_t           err_r, err_nxt;

  logic              out_v_r;
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [BIT_IDX_W-1:0] bit_pos;

  // A pair leaves the input register unless it closes a frame and the
  // result register is still occupied.
  assign advance  = in_v_r && (!fe_r || !out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  assign pair_low  = low_r;
  assign pair_high = high_r;

  always_comb begin
    cnt_nxt    = (cnt_r < COUNTER_MAX) ? cnt_r + CNT_W'(1) : cnt_r;
    shift_nxt  = shift_r;
    err_nxt    = err_r;
    bit_pos    = BIT_IDX_W'(cnt_r - CNT_W'(1));
    status_nxt = ST_OK;
    data_nxt   = '0;

    if (cnt_r == '0) begin
      if (err_r == ST_OK && !flags.start_ok) begin
        err_nxt = ST_BAD_START;
      end
    end else if (cnt_r < FRAME_PAIRS) begin
      if (err_r == ST_OK) begin
        if (flags.zero_ok) begin
          shift_nxt = shift_r;
        end else if (flags.one_ok) begin
          shift_nxt = shift_r | (DATA_W'(1) << bit_pos);
        end else begin
          err_nxt = ST_BAD_BIT;
        end
      end
    end

    if (cnt_r != LAST_IDX) begin
      status_nxt = ST_BAD_LEN;
    end else begin
      status_nxt = err_nxt;
    end
    data_nxt = (status_nxt == ST_OK) ? shift_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      cnt_r   <= '0;
      shift_r <= '0;
      err_r   <= ST_OK;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        if (fe_r) begin
          cnt_r   <= '0;
          shift_r <= '0;
          err_r   <= ST_OK;
        end else begin
          cnt_r   <= cnt_nxt;
          shift_r <= shift_nxt;
          err_r   <= err_nxt;
        end
      end
      if (advance && fe_r) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      low_r  <= in_low_time;
      high_r <= in_high_time;
      fe_r   <= in_frame_end;
    end
    if (advance && fe_r) begin
      status_r <= status_nxt;
      data_r   <= data_nxt;
    end
  end

  assign out_valid     = out_v_r;
  assign out_status    = status_r;
  assign out_data_word = data_r;

  assign state_view.pair_cnt   = cnt_r;
  assign state_view.err_code   = err_r;
  assign state_view.shift_word = shift_r;

endmodule

// ===== rtl/core/nec_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// nec_frame_decoder_unit
// Infrared frame decoder: checks measured pulse pairs against start, zero
// and one templates and assembles a 32-bit word per frame.
// ----------------------------------------------------------------------------
// Usage. Pulse pairs arrive on in_chan, one word per handshake, each with a
// low time, a high time and a frame_end flag on the last pair of a frame.
// The first pair of a frame must match the start template and the next 32
// must match the zero template or, failing that, the one template. When the
// pair carrying frame_end has been processed, one result word appears on
// out_chan with a status and the decoded word (first bit received in bit 0,
// zero unless the status is ok); the frame state then returns to empty.
// Pairs without frame_end produce no result.
// Templates and the tolerance are written through cfg_chan, which is always
// ready; write them only while no frame is in progress.
// The closing pair passes through the input register and then the result
// register before its result can be taken. One pair is accepted every cycle:
// an input register feeds one pass of comparators and state update into the
// result register. If the receiver stalls with a result pending, pairs that
// do not close a frame keep flowing; a closing pair waits in the input
// register, and in_chan.ready drops only then. Reset (rst_n low, synchronous)
// empties both registers, clears the frame state and restores the templates
// to zero and the tolerance to four.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nec_frame_decoder_unit #(
  parameter int unsigned PULSE_WIDTH_BITS = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  nfd_in_if.sink     in_chan,
  nfd_out_if.source  out_chan,
  nfd_cfg_if.sink    cfg_chan
);
  import nfd_pkg::*;

  localparam int unsigned W = PULSE_WIDTH_BITS;

  logic [W-1:0] start_low, start_high, zero_low, zero_high;
  logic [W-1:0] one_low, one_high, tolerance;
  logic [W-1:0] pair_low, pair_high;
  match_flags_t flags;
  status_t      status;
  frame_state_t state_view;

  // The register file never stalls a write.
  assign cfg_chan.ready = 1'b1;

  nfd_cfg_regs #(.W(W)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (cfg_chan.valid),
    .wr_index   (cfg_chan.index),
    .wr_data    (cfg_chan.data),
    .start_low  (start_low),
    .start_high (start_high),
    .zero_low   (zero_low),
    .zero_high  (zero_high),
    .one_low    (one_low),
    .one_high   (one_high),
    .tolerance  (tolerance)
  );

  // Three comparators look at the held pair in parallel; the frame logic
  // decides which verdict applies from the pair count.
  nfd_match #(.W(W)) u_match_start (
    .low_time  (pair_low),
    .high_time (pair_high),
    .exp_low   (start_low),
    .exp_high  (start_high),
    .tolerance (tolerance),
    .hit       (flags.start_ok)
  );

  nfd_match #(.W(W)) u_match_zero (
    .low_time  (pair_low),
    .high_time (pair_high),
    .exp_low   (zero_low),
    .exp_high  (zero_high),
    .tolerance (tolerance),
    .hit       (flags.zero_ok)
  );

  nfd_match #(.W(W)) u_match_one (
    .low_time  (pair_low),
    .high_time (pair_high),
    .exp_low   (one_low),
    .exp_high  (one_high),
    .tolerance (tolerance),
    .hit       (flags.one_ok)
  );

  nfd_frame_ctrl #(.W(W)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_chan.valid),
    .in_ready      (in_chan.ready),
    .in_low_time   (in_chan.low_time),
    .in_high_time  (in_chan.high_time),
    .in_frame_end  (in_chan.frame_end),
    .pair_low      (pair_low),
    .pair_high     (pair_high),
    .flags         (flags),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_status    (status),
    .out_data_word (out_chan.data_word),
    .state_view    (state_view)
  );

  assign out_chan.status = status;

  // A failed frame never carries data.
  `ASSERT_IMPLY(a_no_data_on_fail, out_chan.valid && status != ST_OK, out_chan.data_word == '0, "data word not zero on a failed frame")

  // An error can only have been recorded after at least one pair was counted.
  `ASSERT_IMPLY(a_err_after_pair, state_view.err_code != ST_OK, state_view.pair_cnt != '0, "error recorded with an empty frame")

  // Data bits are set only by pairs after the start pair.
  `ASSERT_IMPLY(a_bits_after_start, state_view.shift_word != '0, state_view.pair_cnt >= CNT_W'(2), "data bit set before any data pair")

endmodule
